### src/elfv_pkg.sv
// ----------------------------------------------------------------------------
// elfv_pkg
// Shared types, status codes and ELF constants for the ELF64 image validator.
// ----------------------------------------------------------------------------
package elfv_pkg;

  localparam int unsigned MAX_RECORDS = 1024;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned STATUS_W   = 5;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 40;
  localparam int unsigned IMG_W      = 32;
  localparam int unsigned RAM_W      = 40;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BYTES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GUEST_RAM   = 1'd1;

  // Item operations.
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 5'd0;
  localparam logic [STATUS_W-1:0] ST_ACCEPT  = 5'd1;
  localparam logic [STATUS_W-1:0] ST_SMALL   = 5'd2;
  localparam logic [STATUS_W-1:0] ST_MAGIC   = 5'd3;
  localparam logic [STATUS_W-1:0] ST_CLASS   = 5'd4;
  localparam logic [STATUS_W-1:0] ST_DATA    = 5'd5;
  localparam logic [STATUS_W-1:0] ST_VERSION = 5'd6;
  localparam logic [STATUS_W-1:0] ST_MACHINE = 5'd7;
  localparam logic [STATUS_W-1:0] ST_TYPE    = 5'd8;
  localparam logic [STATUS_W-1:0] ST_LAYOUT  = 5'd9;
  localparam logic [STATUS_W-1:0] ST_COUNT   = 5'd10;
  localparam logic [STATUS_W-1:0] ST_TABLE   = 5'd11;
  localparam logic [STATUS_W-1:0] ST_FILESZ  = 5'd12;
  localparam logic [STATUS_W-1:0] ST_FILE    = 5'd13;
  localparam logic [STATUS_W-1:0] ST_RAM     = 5'd14;
  localparam logic [STATUS_W-1:0] ST_NOLOAD  = 5'd15;
  localparam logic [STATUS_W-1:0] ST_NOENTRY = 5'd16;
  localparam logic [STATUS_W-1:0] ST_SEQ     = 5'd17;

  // ELF constants.
  localparam logic [31:0] ELF_MAGIC_WORD    = 32'h464C_457F;
  localparam logic [7:0]  ELFCLASS64        = 8'd2;
  localparam logic [7:0]  ELFDATA2LSB       = 8'd1;
  localparam logic [7:0]  VERSION_CURRENT_B = 8'd1;
  localparam logic [31:0] VERSION_CURRENT   = 32'd1;
  localparam logic [15:0] MACHINE_X86_64    = 16'd62;
  localparam logic [15:0] ET_EXEC           = 16'd2;
  localparam logic [31:0] PT_LOAD           = 32'd1;
  localparam int unsigned PF_X_BIT          = 0;
  localparam logic [15:0] EHDR_BYTES        = 16'd64;
  localparam logic [15:0] PHDR_BYTES        = 16'd56;

  typedef struct packed {
    logic              operation;
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] second_word;
    logic [WORD_W-1:0] third_word;
    logic [WORD_W-1:0] fourth_word;
    logic [WORD_W-1:0] fifth_word;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                done_res;
    logic [WORD_W-1:0]   entry_address;
    logic [IDX_W-1:0]    record_index;
  } result_t;

  // Outcome of one program header check.
  typedef struct packed {
    logic                is_load;
    logic                covers_entry;
    logic [STATUS_W-1:0] err;
  } rec_chk_t;

endpackage

### src/elfv_if.sv
// ----------------------------------------------------------------------------
// elfv_if
// Channel interfaces: input items, result items and configuration writes.
// ----------------------------------------------------------------------------
interface elfv_item_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [elfv_pkg::WORD_W-1:0] first_word;
  logic [elfv_pkg::WORD_W-1:0] second_word;
  logic [elfv_pkg::WORD_W-1:0] third_word;
  logic [elfv_pkg::WORD_W-1:0] fourth_word;
  logic [elfv_pkg::WORD_W-1:0] fifth_word;

  modport source (output valid, operation, first_word, second_word, third_word,
                  fourth_word, fifth_word, input ready);
  modport sink   (input valid, operation, first_word, second_word, third_word,
                  fourth_word, fifth_word, output ready);
endinterface

interface elfv_result_if;
  logic                          valid;
  logic                          ready;
  logic [elfv_pkg::STATUS_W-1:0] status;
  logic                          done_res;
  logic [elfv_pkg::WORD_W-1:0]   entry_address;
  logic [elfv_pkg::IDX_W-1:0]    record_index;

  modport source (output valid, status, done_res, entry_address, record_index,
                  input ready);
  modport sink   (input valid, status, done_res, entry_address, record_index,
                  output ready);
endinterface

interface elfv_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [elfv_pkg::CFG_IDX_W-1:0]  index;
  logic [elfv_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/elfv_hdr_check.sv
// ----------------------------------------------------------------------------
// elfv_hdr_check
// Combinational check of the ELF64 file header words.
// ----------------------------------------------------------------------------
module elfv_hdr_check #(
  parameter int unsigned MaxRecords = elfv_pkg::MAX_RECORDS,
  localparam int unsigned CntW = $clog2(MaxRecords + 1)
) (
  input  logic [elfv_pkg::WORD_W-1:0]   first_word_i,
  input  logic [elfv_pkg::WORD_W-1:0]   second_word_i,
  input  logic [elfv_pkg::WORD_W-1:0]   fourth_word_i,
  input  logic [elfv_pkg::WORD_W-1:0]   fifth_word_i,
  input  logic [elfv_pkg::IMG_W-1:0]    image_bytes_i,
  output logic [elfv_pkg::STATUS_W-1:0] status_o,
  output logic [CntW-1:0]               count_o
);

  logic [15:0]                 n;
  logic [21:0]                 table_len;
  logic [elfv_pkg::WORD_W-1:0] img;
  logic [elfv_pkg::WORD_W-1:0] room;
  logic                        table_fits;

  assign n   = fifth_word_i[47:32];
  assign img = elfv_pkg::WORD_W'(image_bytes_i);

  // n * 56 as (n << 6) - (n << 3).
  assign table_len  = {n, 6'd0} - {3'd0, n, 3'd0};
  assign room       = img - fourth_word_i;
  assign table_fits = (fourth_word_i <= img) &&
                      (elfv_pkg::WORD_W'(table_len) <= room);
  assign count_o    = CntW'(n);

  always_comb begin
    priority if (image_bytes_i < elfv_pkg::IMG_W'(elfv_pkg::EHDR_BYTES)) begin
      status_o = elfv_pkg::ST_SMALL;
    end else if (first_word_i[31:0] != elfv_pkg::ELF_MAGIC_WORD) begin
      status_o = elfv_pkg::ST_MAGIC;
    end else if (first_word_i[39:32] != elfv_pkg::ELFCLASS64) begin
      status_o = elfv_pkg::ST_CLASS;
    end else if (first_word_i[47:40] != elfv_pkg::ELFDATA2LSB) begin
      status_o = elfv_pkg::ST_DATA;
    end else if (first_word_i[55:48] != elfv_pkg::VERSION_CURRENT_B ||
                 second_word_i[63:32] != elfv_pkg::VERSION_CURRENT) begin
      status_o = elfv_pkg::ST_VERSION;
    end else if (second_word_i[31:16] != elfv_pkg::MACHINE_X86_64) begin
      status_o = elfv_pkg::ST_MACHINE;
    end else if (second_word_i[15:0] != elfv_pkg::ET_EXEC) begin
      status_o = elfv_pkg::ST_TYPE;
    end else if (fifth_word_i[15:0] != elfv_pkg::EHDR_BYTES ||
                 fifth_word_i[31:16] != elfv_pkg::PHDR_BYTES) begin
      status_o = elfv_pkg::ST_LAYOUT;
    end else if (n == 16'd0 || n > 16'(MaxRecords)) begin
      status_o = elfv_pkg::ST_COUNT;
    end else if (!table_fits) begin
      status_o = elfv_pkg::ST_TABLE;
    end else begin
      status_o = elfv_pkg::ST_OK;
    end
  end

endmodule

### src/elfv_rec_check.sv
// ----------------------------------------------------------------------------
// elfv_rec_check
// Combinational check of one program header against file and guest RAM.
// ----------------------------------------------------------------------------
module elfv_rec_check (
  input  logic [elfv_pkg::WORD_W-1:0] first_word_i,
  input  logic [elfv_pkg::WORD_W-1:0] offset_i,
  input  logic [elfv_pkg::WORD_W-1:0] paddr_i,
  input  logic [elfv_pkg::WORD_W-1:0] filesz_i,
  input  logic [elfv_pkg::WORD_W-1:0] memsz_i,
  input  logic [elfv_pkg::IMG_W-1:0]  image_bytes_i,
  input  logic [elfv_pkg::RAM_W-1:0]  guest_ram_bytes_i,
  input  logic [elfv_pkg::WORD_W-1:0] saved_entry_i,
  output elfv_pkg::rec_chk_t          chk_o
);

  logic [elfv_pkg::WORD_W-1:0] img;
  logic [elfv_pkg::WORD_W-1:0] ram;
  logic [elfv_pkg::WORD_W-1:0] file_room;
  logic [elfv_pkg::WORD_W-1:0] ram_room;
  logic [elfv_pkg::WORD_W-1:0] entry_off;
  logic                        fits_file;
  logic                        fits_ram;
  logic                        exec;

  assign img       = elfv_pkg::WORD_W'(image_bytes_i);
  assign ram       = elfv_pkg::WORD_W'(guest_ram_bytes_i);
  assign file_room = img - offset_i;
  assign ram_room  = ram - paddr_i;
  assign entry_off = saved_entry_i - paddr_i;
  assign fits_file = (offset_i <= img) && (filesz_i <= file_room);
  assign fits_ram  = (paddr_i <= ram) && (memsz_i <= ram_room);
  assign exec      = first_word_i[32 + elfv_pkg::PF_X_BIT];

  always_comb begin
    chk_o.is_load      = (first_word_i[31:0] == elfv_pkg::PT_LOAD);
    chk_o.covers_entry = exec && (saved_entry_i >= paddr_i) && (entry_off < memsz_i);
    priority if (!chk_o.is_load) begin
      chk_o.err = elfv_pkg::ST_OK;
    end else if (memsz_i < filesz_i) begin
      chk_o.err = elfv_pkg::ST_FILESZ;
    end else if (!fits_file) begin
      chk_o.err = elfv_pkg::ST_FILE;
    end else if (!fits_ram) begin
      chk_o.err = elfv_pkg::ST_RAM;
    end else begin
      chk_o.err = elfv_pkg::ST_OK;
    end
  end

endmodule

### src/elf64_image_validator.sv
// ----------------------------------------------------------------------------
// elf64_image_validator
// Flow: a transaction accepted at the input is held in the input register,
// checked there, and its result is registered in the result register that
// drives the output. Throughput: one item per cycle; the input stalls only
// while both registers are full and the result is not taken.
// Reset: rst_ni clears the phase, per-image state, latched error and both
// configuration registers to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module elf64_image_validator #(
  parameter int unsigned MaxRecords = elfv_pkg::MAX_RECORDS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  elfv_item_if.sink     item_i,
  elfv_cfg_if.sink      cfg_i,
  elfv_result_if.source result_o
);

  // Record counters must hold the largest table size.
  localparam int unsigned CntW = $clog2(MaxRecords + 1);

  // Phase codes of the image sequencer.
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_RECS = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  // Configuration registers. Writes are always taken and act at once.
  logic [elfv_pkg::IMG_W-1:0] image_bytes_q;
  logic [elfv_pkg::RAM_W-1:0] guest_ram_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_bytes_q <= '0;
      guest_ram_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        elfv_pkg::REG_IMAGE_BYTES: image_bytes_q <= cfg_i.data[elfv_pkg::IMG_W-1:0];
        elfv_pkg::REG_GUEST_RAM:   guest_ram_q   <= cfg_i.data[elfv_pkg::RAM_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake. The input register is refilled in the same cycle
  // that it hands its item to the result register, so a stalled consumer
  // only holds things up once both registers are full.
  logic              in_vld_q;
  elfv_pkg::item_t   in_q;
  logic              out_vld_q;
  elfv_pkg::result_t out_q;
  logic              out_free;
  logic              proc;
  logic              in_acc;

  assign out_free     = !out_vld_q || result_o.ready;
  assign proc         = in_vld_q && out_free;
  assign item_i.ready = !in_vld_q || out_free;
  assign in_acc       = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (proc) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q.operation   <= item_i.operation;
      in_q.first_word  <= item_i.first_word;
      in_q.second_word <= item_i.second_word;
      in_q.third_word  <= item_i.third_word;
      in_q.fourth_word <= item_i.fourth_word;
      in_q.fifth_word  <= item_i.fifth_word;
    end
  end

  // Per-image state.
  logic [1:0]                    phase_q, phase_d;
  logic [elfv_pkg::WORD_W-1:0]   entry_q, entry_d;
  logic [CntW-1:0]               expected_q, expected_d;
  logic [CntW-1:0]               seen_q, seen_d;
  logic                          load_q, load_d;
  logic                          cover_q, cover_d;
  logic [elfv_pkg::STATUS_W-1:0] err_q, err_d;
  elfv_pkg::result_t             res_d;

  // Check units, both evaluated on the item sitting in the input register.
  logic [elfv_pkg::STATUS_W-1:0] hdr_status;
  logic [CntW-1:0]               hdr_count;
  elfv_pkg::rec_chk_t            rec_chk;

  elfv_hdr_check #(
    .MaxRecords (MaxRecords)
  ) u_hdr_check (
    .first_word_i  (in_q.first_word),
    .second_word_i (in_q.second_word),
    .fourth_word_i (in_q.fourth_word),
    .fifth_word_i  (in_q.fifth_word),
    .image_bytes_i (image_bytes_q),
    .status_o      (hdr_status),
    .count_o       (hdr_count)
  );

  elfv_rec_check u_rec_check (
    .first_word_i      (in_q.first_word),
    .offset_i          (in_q.second_word),
    .paddr_i           (in_q.third_word),
    .filesz_i          (in_q.fourth_word),
    .memsz_i           (in_q.fifth_word),
    .image_bytes_i     (image_bytes_q),
    .guest_ram_bytes_i (guest_ram_q),
    .saved_entry_i     (entry_q),
    .chk_o             (rec_chk)
  );

  logic [CntW-1:0] seen_inc;
  logic            last_rec;

  assign seen_inc = seen_q + CntW'(1);
  assign last_rec = (seen_inc >= expected_q);

  always_comb begin
    phase_d    = phase_q;
    entry_d    = entry_q;
    expected_d = expected_q;
    seen_d     = seen_q;
    load_d     = load_q;
    cover_d    = cover_q;
    err_d      = err_q;

    res_d.status        = elfv_pkg::ST_OK;
    res_d.done_res      = 1'b0;
    res_d.entry_address = '0;
    res_d.record_index  = '0;

    if (in_q.operation == elfv_pkg::OP_HEADER) begin
      if (phase_q == PH_RECS) begin
        // A header in the middle of a table ends the image.
        if (err_q == elfv_pkg::ST_OK) begin
          err_d = elfv_pkg::ST_SEQ;
        end
        phase_d        = PH_DONE;
        res_d.status   = err_d;
        res_d.done_res = 1'b1;
      end else begin
        // A fresh image starts; the per-image state is cleared or loaded from the header.
        entry_d = in_q.third_word;
        seen_d  = '0;
        load_d  = 1'b0;
        cover_d = 1'b0;
        if (hdr_status != elfv_pkg::ST_OK) begin
          expected_d     = '0;
          err_d          = hdr_status;
          phase_d        = PH_DONE;
          res_d.status   = hdr_status;
          res_d.done_res = 1'b1;
        end else begin
          expected_d = hdr_count;
          err_d      = elfv_pkg::ST_OK;
          phase_d    = PH_RECS;
        end
      end
    end else if (phase_q != PH_RECS) begin
      // A record without a header in front of it.
      if (err_q == elfv_pkg::ST_OK) begin
        err_d = elfv_pkg::ST_SEQ;
      end
      phase_d        = PH_DONE;
      res_d.status   = err_d;
      res_d.done_res = 1'b1;
    end else begin
      // Records after the first error are consumed without a check.
      if (err_q == elfv_pkg::ST_OK) begin
        load_d = load_q || rec_chk.is_load;
        if (rec_chk.err != elfv_pkg::ST_OK) begin
          err_d = rec_chk.err;
        end else begin
          cover_d = cover_q || (rec_chk.is_load && rec_chk.covers_entry);
        end
      end
      seen_d             = seen_inc;
      res_d.record_index = elfv_pkg::IDX_W'(seen_q);
      if (!last_rec) begin
        res_d.status   = err_d;
        res_d.done_res = (err_d != elfv_pkg::ST_OK);
      end else begin
        phase_d = PH_DONE;
        if (err_d == elfv_pkg::ST_OK) begin
          if (!load_d) begin
            err_d = elfv_pkg::ST_NOLOAD;
          end else if (!cover_d) begin
            err_d = elfv_pkg::ST_NOENTRY;
          end
        end
        res_d.done_res = 1'b1;
        if (err_d != elfv_pkg::ST_OK) begin
          res_d.status = err_d;
        end else begin
          res_d.status        = elfv_pkg::ST_ACCEPT;
          res_d.entry_address = entry_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_WAIT;
      entry_q    <= '0;
      expected_q <= '0;
      seen_q     <= '0;
      load_q     <= 1'b0;
      cover_q    <= 1'b0;
      err_q      <= elfv_pkg::ST_OK;
    end else if (proc) begin
      phase_q    <= phase_d;
      entry_q    <= entry_d;
      expected_q <= expected_d;
      seen_q     <= seen_d;
      load_q     <= load_d;
      cover_q    <= cover_d;
      err_q      <= err_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_q <= res_d;
    end
  end

  assign result_o.valid         = out_vld_q;
  assign result_o.status        = out_q.status;
  assign result_o.done_res      = out_q.done_res;
  assign result_o.entry_address = out_q.entry_address;
  assign result_o.record_index  = out_q.record_index;

endmodule
